FILE: rtl/core/erlh_pkg.sv
// Types, codes and the sequencer microprogram shared by the event log core.
`timescale 1ns / 1ps

package erlh_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int FILL_W      = 7;
  localparam int CNT_W       = 32;

  // Item kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_REC   = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] item_index;
    logic [2:0]  item_class;
    logic [31:0] time_ticks;
    logic [6:0]  read_limit;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [15:0] entry_index;
    logic [2:0]  entry_class;
    logic [31:0] entry_time;
    logic        has_entry;
    logic        last;
    logic [6:0]  fill_count;
    logic [31:0] class0_total;
    logic [31:0] class1_total;
    logic [31:0] class2_total;
    logic [31:0] class3_total;
    logic [31:0] class4_total;
  } out_word_t;

  // One stored log entry
  typedef struct packed {
    logic [15:0] idx;
    logic [2:0]  cls;
    logic [31:0] t;
  } entry_t;

  // Microprogram step addresses
  typedef logic [2:0] upc_t;
  localparam upc_t U_IDLE   = 3'd0;
  localparam upc_t U_REC    = 3'd1;
  localparam upc_t U_CLR    = 3'd2;
  localparam upc_t U_RDSET  = 3'd3;
  localparam upc_t U_STAT   = 3'd4;
  localparam upc_t U_RDADDR = 3'd5;
  localparam upc_t U_RDDATA = 3'd6;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_REC,
    OP_CLR,
    OP_RDSET,
    OP_RDISS,
    OP_LDENT,
    OP_LDSTAT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_NZ,
    C_OUTFREE,
    C_OUTMORE
  } cond_t;

  typedef struct packed {
    logic  ready;
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctl_word_t;

  // Status the sequencer branches on
  typedef struct packed {
    logic  accept;
    kind_t kind;
    logic  n_nz;
    logic  out_free;
    logic  more;
  } seq_stat_t;

  // Microprogram ROM
  function automatic ctl_word_t ucode_rom(input upc_t a);
    ctl_word_t w;
    unique case (a)
      U_IDLE:   w = '{ready: 1'b1, op: OP_NONE,   cond: C_DISPATCH, target: U_IDLE};
      U_REC:    w = '{ready: 1'b0, op: OP_REC,    cond: C_ALWAYS,   target: U_STAT};
      U_CLR:    w = '{ready: 1'b0, op: OP_CLR,    cond: C_ALWAYS,   target: U_STAT};
      U_RDSET:  w = '{ready: 1'b0, op: OP_RDSET,  cond: C_NZ,       target: U_RDADDR};
      U_STAT:   w = '{ready: 1'b0, op: OP_LDSTAT, cond: C_OUTFREE,  target: U_IDLE};
      U_RDADDR: w = '{ready: 1'b0, op: OP_RDISS,  cond: C_ALWAYS,   target: U_RDDATA};
      U_RDDATA: w = '{ready: 1'b0, op: OP_LDENT,  cond: C_OUTMORE,  target: U_RDADDR};
      default:  w = '{ready: 1'b0, op: OP_NONE,   cond: C_ALWAYS,   target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/erlh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module erlh_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/erlh_useq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
`timescale 1ns / 1ps

module erlh_useq
  import erlh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output ctl_word_t ctl
);

  upc_t upc_r;
  upc_t upc_nxt;

  assign ctl = ucode_rom(upc_r);

  // Next step
  always_comb begin
    upc_nxt = upc_r;
    unique case (ctl.cond)
      C_ALWAYS: begin
        upc_nxt = ctl.target;
      end
      C_DISPATCH: begin
        if (stat.accept) begin
          if (stat.kind == KIND_REC) begin
            upc_nxt = U_REC;
          end else if (stat.kind == KIND_READ) begin
            upc_nxt = U_RDSET;
          end else if (stat.kind == KIND_CLEAR) begin
            upc_nxt = U_CLR;
          end else begin
            upc_nxt = U_STAT;
          end
        end
      end
      C_NZ: begin
        upc_nxt = stat.n_nz ? ctl.target : upc_t'(upc_r + 3'd1);
      end
      C_OUTFREE: begin
        if (stat.out_free) begin
          upc_nxt = ctl.target;
        end
      end
      C_OUTMORE: begin
        if (stat.out_free) begin
          upc_nxt = stat.more ? ctl.target : U_IDLE;
        end
      end
      default: begin
        upc_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: rtl/core/event_ring_log_with_histogram_core.sv
// Top level of the circular event log with five-class histogram.
`timescale 1ns / 1ps

// Circular event log of LOG_DEPTH entries with saturating per-class counters.
// Control is a seven-step microprogram that advances one step per cycle, but
// a step that loads a result holds while the output register is still full.
// A record or clear word runs its update step and then a status step, and an
// unused-kind word only the status step; each yields one status result. A read
// word returns n entries newest first after a setup step, or one status result
// when n is zero. Each entry costs an address step and a data step, since the
// log memory has one registered read port. A finished result sits in an
// output register, so the next word is accepted while it waits.

module event_ring_log_with_histogram_core
  import erlh_pkg::*;
#(
  parameter int LOG_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int PTR_W = $clog2(LOG_DEPTH);
  localparam int ENT_W = $bits(entry_t);

  ctl_word_t ctl;
  seq_stat_t stat;

  in_word_t            in_r;
  logic [PTR_W-1:0]    wp_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   cnt_r;
  logic [CNT_W-1:0]    cls_cnt_r [NUM_CLASSES];
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic                accept;
  logic                out_free;
  logic [2:0]          rec_cls;
  logic [FILL_W-1:0]   n_w;
  logic [PTR_W-1:0]    wp_prev;
  logic [PTR_W-1:0]    rd_prev;
  logic                ram_we;
  logic                ram_re;
  entry_t              wr_ent;
  logic [ENT_W-1:0]    rd_raw;
  entry_t              rd_ent;
  logic                do_ldent;
  logic                do_ldstat;

  assign accept   = in_valid & in_ready;
  assign in_ready = ctl.ready;
  assign out_free = ~out_valid_r | out_ready;

  // Class folding and read count
  assign rec_cls = (in_r.item_class > 3'(NUM_CLASSES - 1)) ? 3'd0 : in_r.item_class;
  assign n_w     = (fill_r < in_r.read_limit) ? fill_r : in_r.read_limit;

  // Pointer steps back with wrap
  assign wp_prev = (wp_r == '0) ? PTR_W'(LOG_DEPTH - 1) : PTR_W'(wp_r - 1'b1);
  assign rd_prev = (rd_ptr_r == '0) ? PTR_W'(LOG_DEPTH - 1) : PTR_W'(rd_ptr_r - 1'b1);

  assign stat = '{accept: accept, kind: in_data.kind, n_nz: (n_w != '0),
                  out_free: out_free, more: (cnt_r > 7'd1)};

  erlh_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Log memory
  assign ram_we = (ctl.op == OP_REC);
  assign ram_re = (ctl.op == OP_RDISS);
  assign wr_ent = '{idx: in_r.item_index, cls: rec_cls, t: in_r.time_ticks};
  assign rd_ent = entry_t'(rd_raw);

  erlh_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LOG_DEPTH),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (rd_raw)
  );

  assign do_ldent  = (ctl.op == OP_LDENT) & out_free;
  assign do_ldstat = (ctl.op == OP_LDSTAT) & out_free;

  // Input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // Log pointers, fill count and histogram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cls_cnt_r[c] <= '0;
      end
    end else begin
      if (ctl.op == OP_REC) begin
        wp_r <= (wp_r == PTR_W'(LOG_DEPTH - 1)) ? '0 : PTR_W'(wp_r + 1'b1);
        if (fill_r < FILL_W'(LOG_DEPTH)) begin
          fill_r <= FILL_W'(fill_r + 1'b1);
        end
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if ((rec_cls == 3'(c)) && (cls_cnt_r[c] != '1)) begin
            cls_cnt_r[c] <= CNT_W'(cls_cnt_r[c] + 1'b1);
          end
        end
      end else if (ctl.op == OP_CLR) begin
        wp_r   <= '0;
        fill_r <= '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          cls_cnt_r[c] <= '0;
        end
      end
    end
  end

  // Read walk: newest first, count of words left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (ctl.op == OP_RDSET) begin
        cnt_r    <= n_w;
        rd_ptr_r <= wp_prev;
      end else if (ctl.op == OP_RDISS) begin
        rd_ptr_r <= rd_prev;
      end else if (do_ldent) begin
        cnt_r <= FILL_W'(cnt_r - 1'b1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_ldent || do_ldstat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ldent || do_ldstat) begin
      out_data_r.entry_index  <= do_ldent ? rd_ent.idx : 16'd0;
      out_data_r.entry_class  <= do_ldent ? rd_ent.cls : 3'd0;
      out_data_r.entry_time   <= do_ldent ? rd_ent.t : 32'd0;
      out_data_r.has_entry    <= do_ldent;
      out_data_r.last         <= do_ldstat | (cnt_r == 7'd1);
      out_data_r.fill_count   <= fill_r;
      out_data_r.class0_total <= cls_cnt_r[0];
      out_data_r.class1_total <= cls_cnt_r[1];
      out_data_r.class2_total <= cls_cnt_r[2];
      out_data_r.class3_total <= cls_cnt_r[3];
      out_data_r.class4_total <= cls_cnt_r[4];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LOG_DEPTH))
    else $error("fill count above log depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PTR_W'(LOG_DEPTH - 1))
    else $error("write pointer out of range");

  a_entry_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.has_entry) |-> (out_data_r.fill_count != '0))
    else $error("entry returned from an empty log");

  a_rec_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.kind == KIND_REC) && (fill_r < FILL_W'(LOG_DEPTH)))
      |=> ##1 (fill_r == FILL_W'($past(fill_r, 2) + 1'b1)))
    else $error("record did not raise fill count");

endmodule

FILE: dv/event_ring_log_with_histogram_core_tb.sv
// Self-checking testbench for the circular event log with class histogram.
`timescale 1ns / 1ps

module event_ring_log_with_histogram_core_tb;
  import erlh_pkg::*;

  localparam int LOG_DEPTH = 64;
  // Kind code the block leaves unused; it only reports status
  localparam kind_t KIND_SPARE = 2'd3;
  localparam int TARGET_WORDS = 220;
  localparam int HOLD_CYCLES = 150;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Predicted log contents and counters
  entry_t      log_store [LOG_DEPTH];
  int          log_wptr;
  int          log_fill;
  logic [31:0] class_hist [NUM_CLASSES];
  out_word_t   pending_results [$];

  // Idle control for sender and receiver
  bit tx_idle;
  bit rx_idle;
  int rx_hold_req;

  // Run statistics
  int mismatches;
  int words_sent;
  int kind_count [4];
  int results_seen;
  int entries_seen;
  int overwrites;
  int longest_read;

  event_ring_log_with_histogram_core #(
    .LOG_DEPTH(LOG_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Result word as it should look given the current predicted state
  function automatic out_word_t result_word(input entry_t e, input logic has,
                                            input logic fin);
    out_word_t o;
    o = '0;
    if (has) begin
      o.entry_index = e.idx;
      o.entry_class = e.cls;
      o.entry_time  = e.t;
    end
    o.has_entry    = has;
    o.last         = fin;
    o.fill_count   = 7'(log_fill);
    o.class0_total = class_hist[0];
    o.class1_total = class_hist[1];
    o.class2_total = class_hist[2];
    o.class3_total = class_hist[3];
    o.class4_total = class_hist[4];
    return o;
  endfunction

  // Apply one accepted word to the predicted log and queue its results
  function automatic void predict_log(input in_word_t w);
    logic [2:0] cls;
    int         n;
    int         pos;
    entry_t     e;
    e = '0;
    case (w.kind)
      KIND_REC: begin
        cls = (w.item_class < NUM_CLASSES) ? w.item_class : 3'd0;
        if (log_fill == LOG_DEPTH) overwrites++;
        log_store[log_wptr] = '{idx: w.item_index, cls: cls, t: w.time_ticks};
        log_wptr = (log_wptr + 1) % LOG_DEPTH;
        if (log_fill < LOG_DEPTH) log_fill++;
        if (class_hist[cls] != 32'hFFFF_FFFF) class_hist[cls]++;
        pending_results.push_back(result_word(e, 1'b0, 1'b1));
      end
      KIND_READ: begin
        n = (log_fill < int'(w.read_limit)) ? log_fill : int'(w.read_limit);
        if (n > longest_read) longest_read = n;
        if (n == 0) begin
          pending_results.push_back(result_word(e, 1'b0, 1'b1));
        end else begin
          // newest first, walking back from the write pointer
          for (int i = 0; i < n; i++) begin
            pos = (log_wptr + LOG_DEPTH - 1 - i) % LOG_DEPTH;
            pending_results.push_back(result_word(log_store[pos], 1'b1, i == n - 1));
          end
        end
      end
      KIND_CLEAR: begin
        log_wptr = 0;
        log_fill = 0;
        foreach (class_hist[c]) class_hist[c] = '0;
        pending_results.push_back(result_word(e, 1'b0, 1'b1));
      end
      default: begin
        pending_results.push_back(result_word(e, 1'b0, 1'b1));
      end
    endcase
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d %s: expected %h, got %h",
                 $time, results_seen, name, want, got);
    end
  endfunction

  function automatic in_word_t make_word(input kind_t k, input logic [15:0] idx,
                                         input logic [2:0] cls, input logic [31:0] t,
                                         input logic [6:0] lim);
    in_word_t w;
    w.kind       = k;
    w.item_index = idx;
    w.item_class = cls;
    w.time_ticks = t;
    w.read_limit = lim;
    return w;
  endfunction

  // Mostly short reads, now and then the whole log or more
  function automatic logic [6:0] rand_read_limit();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 7'($urandom_range(0, 8));
    if (pick < 9) return 7'($urandom_range(9, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  function automatic in_word_t rand_word(input kind_t k);
    return make_word(k, 16'($urandom), 3'($urandom_range(0, 7)), $urandom,
                     (k == KIND_READ) ? rand_read_limit() : 7'($urandom_range(0, 127)));
  endfunction

  // Offer one word, after a random gap while tx_idle is set, and hold it until accepted
  task automatic send_word(input in_word_t w);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_log(w);
    words_sent++;
    kind_count[w.kind]++;
  endtask

  // Receiver: random stall after each word while rx_idle is set, plus long holds on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (hold_left == 0 && rx_hold_req > 0) begin
          hold_left   = rx_hold_req;
          rx_hold_req = 0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
          stall_left = rx_idle ? $urandom_range(0, 11) : 0;
          out_ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
          stall_left--;
          out_ready <= (stall_left == 0);
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Result checker: each accepted word against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.has_entry) entries_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result word: %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        cmp_field("entry_index", want.entry_index, out_data.entry_index);
        cmp_field("entry_class", want.entry_class, out_data.entry_class);
        cmp_field("entry_time", want.entry_time, out_data.entry_time);
        cmp_field("has_entry", want.has_entry, out_data.has_entry);
        cmp_field("last", want.last, out_data.last);
        cmp_field("fill_count", want.fill_count, out_data.fill_count);
        cmp_field("class0_total", want.class0_total, out_data.class0_total);
        cmp_field("class1_total", want.class1_total, out_data.class1_total);
        cmp_field("class2_total", want.class2_total, out_data.class2_total);
        cmp_field("class3_total", want.class3_total, out_data.class3_total);
        cmp_field("class4_total", want.class4_total, out_data.class4_total);
      end
    end
  end

  // Empty log reads, field extremes, class folding, read limits, clear
  task automatic test_corner_words();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word(make_word(KIND_READ, 16'h1234, 3'd2, 32'h0, 7'd5));
    send_word(make_word(KIND_READ, 16'h0, 3'd0, 32'h0, 7'd0));
    send_word(make_word(KIND_SPARE, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 7'd127));
    send_word(make_word(KIND_REC, 16'h0000, 3'd0, 32'h0000_0000, 7'd0));
    send_word(make_word(KIND_REC, 16'hFFFF, 3'd4, 32'hFFFF_FFFF, 7'd127));
    for (int c = 1; c <= 3; c++)
      send_word(make_word(KIND_REC, 16'($urandom), 3'(c), $urandom, 7'd0));
    // classes past the last one fold into class zero
    for (int c = 5; c <= 7; c++)
      send_word(make_word(KIND_REC, 16'($urandom), 3'(c), $urandom, 7'd64));
    send_word(make_word(KIND_READ, 16'h0, 3'd0, 32'h0, 7'd0));
    send_word(make_word(KIND_READ, 16'h0, 3'd0, 32'h0, 7'd1));
    send_word(make_word(KIND_READ, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 7'd127));
    send_word(make_word(KIND_READ, 16'h0, 3'd0, 32'h0, 7'd64));
    send_word(make_word(KIND_SPARE, 16'h0, 3'd0, 32'h0, 7'd0));
    send_word(make_word(KIND_CLEAR, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 7'd127));
    send_word(make_word(KIND_READ, 16'h0, 3'd0, 32'h0, 7'd64));
    send_word(make_word(KIND_REC, 16'hA5A5, 3'd4, 32'h8000_0001, 7'd3));
    send_word(make_word(KIND_READ, 16'h0, 3'd0, 32'h0, 7'd2));
  endtask

  // Receiver stops for a long stretch while records keep coming
  task automatic test_output_backpressure();
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (24) send_word(rand_word(KIND_REC));
    send_word(make_word(KIND_READ, 16'($urandom), 3'($urandom), $urandom, 7'd16));
  endtask

  // Record bursts closed by reads, with occasional clears and stray words
  task automatic test_random_traffic();
    int pick;
    int burst;
    while (words_sent < TARGET_WORDS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 75) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_word(rand_word(KIND_REC));
        send_word(rand_word(KIND_READ));
      end else if (pick < 78) begin
        send_word(rand_word(KIND_CLEAR));
      end else if (pick < 85) begin
        send_word(rand_word(KIND_SPARE));
      end else begin
        send_word(rand_word(kind_t'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    int waited;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    rx_hold_req = 0;
    log_wptr    = 0;
    log_fill    = 0;
    foreach (class_hist[c]) class_hist[c] = '0;
    foreach (log_store[i]) log_store[i] = '0;
    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_words();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;

    // drain outstanding results, then give the block a few more cycles
    waited = 0;
    while (pending_results.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d predicted result words never arrived", pending_results.size());
    end

    $display("Sent %0d words: %0d records, %0d reads, %0d clears, %0d of unused kind.",
             words_sent, kind_count[KIND_REC], kind_count[KIND_READ],
             kind_count[KIND_CLEAR], kind_count[KIND_SPARE]);
    $display("Checked %0d results (%0d log entries), %0d overwrites, longest read %0d.",
             results_seen, entries_seen, overwrites, longest_read);
    if (mismatches == 0) begin
      $display("event_ring_log_with_histogram_core regression: pass");
    end else begin
      $display("event_ring_log_with_histogram_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timed out with %0d result words outstanding", pending_results.size());
    $display("event_ring_log_with_histogram_core regression: fail");
    $finish;
  end

endmodule
